### hw/rtl/cbft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbft_pkg
// Shared constants and types of the character bigram frequency table.
// ----------------------------------------------------------------------------
package cbft_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 21;
    localparam int INDEX_W  = 12;
    localparam int STATUS_W = 3;
    localparam int PCOUNT_W = 32;
    localparam int USED_W   = 13;

    localparam logic [OPCODE_W-1:0] OP_CHAR = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_EOL  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NO_PAIR  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INCR     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READ_OOR = 3'd5;

    typedef struct packed {
        logic                load;
        logic                rd;
        logic                wr_hit;
        logic                wr_new;
        logic                set_res;
        logic [STATUS_W-1:0] res_status;
        logic                emit;
    } t_cmd;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                pair;
        logic                in_range;
        logic                more;
        logic                rd_vld;
        logic                hit;
        logic                full;
        logic                out_blocked;
    } t_sts;

endpackage
`default_nettype wire

### hw/rtl/cbft_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbft_ctrl
// Controller that sequences each request through decode, table search,
// table read and result delivery.
// ----------------------------------------------------------------------------
module cbft_ctrl
    import cbft_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_RDWAIT,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_CHAR: begin
                        if (i_sts.pair) begin
                            n_state = S_SEARCH;
                        end else begin
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_status = ST_NO_PAIR;
                            n_state          = S_EMIT;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.in_range) begin
                            o_cmd.rd = 1'b1;
                            n_state  = S_RDWAIT;
                        end else begin
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_status = ST_READ_OOR;
                            n_state          = S_EMIT;
                        end
                    end
                    default: begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_NO_PAIR;
                        n_state          = S_EMIT;
                    end
                endcase
            end
            S_SEARCH: begin
                if (i_sts.rd_vld && i_sts.hit) begin
                    o_cmd.wr_hit     = 1'b1;
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_INCR;
                    n_state          = S_EMIT;
                end else if (!i_sts.more && !i_sts.rd_vld) begin
                    o_cmd.set_res = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.res_status = ST_FULL;
                    end else begin
                        o_cmd.wr_new     = 1'b1;
                        o_cmd.res_status = ST_INSERT;
                    end
                    n_state = S_EMIT;
                end else begin
                    o_cmd.rd = i_sts.more;
                end
            end
            S_RDWAIT: begin
                o_cmd.set_res    = 1'b1;
                o_cmd.res_status = ST_READ_OK;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/cbft_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbft_dp
// Datapath holding the pair key and count memories, the previous character,
// the search pointer and the result output register.
// ----------------------------------------------------------------------------
module cbft_dp
    import cbft_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic [CHAR_W-1:0]   i_code_point,
    input  wire logic [INDEX_W-1:0]  i_read_index,
    input  wire logic                i_stall,
    output logic                     o_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [INDEX_W-1:0]       o_entry_index,
    output logic [CHAR_W-1:0]        o_first_char,
    output logic [CHAR_W-1:0]        o_second_char,
    output logic [PCOUNT_W-1:0]      o_pair_count,
    output logic [USED_W-1:0]        o_entries_in_use,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int KEY_W = 2 * CHAR_W;

    typedef logic [CMP_W-1:0]       t_cmp;
    typedef logic [KEY_W-1:0]       t_key;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    t_key   key_mem [TABLE_DEPTH];
    t_count cnt_mem [TABLE_DEPTH];

    logic [CHAR_W-1:0]   r_prev;
    logic                r_prev_vld;
    logic [OPCODE_W-1:0] r_op;
    logic                r_pair;
    logic [INDEX_W-1:0]  r_ri;
    logic [CHAR_W-1:0]   r_key_a;
    logic [CHAR_W-1:0]   r_key_b;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_addr;
    logic                r_rd_vld;
    t_key                r_rd_key;
    t_count              r_rd_cnt;
    logic [IDX_W-1:0]    r_rd_idx;

    logic [STATUS_W-1:0] r_res_status;
    logic [INDEX_W-1:0]  r_res_idx;
    logic [CHAR_W-1:0]   r_res_a;
    logic [CHAR_W-1:0]   r_res_b;
    logic [PCOUNT_W-1:0] r_res_cnt;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [INDEX_W-1:0]  r_out_idx;
    logic [CHAR_W-1:0]   r_out_a;
    logic [CHAR_W-1:0]   r_out_b;
    logic [PCOUNT_W-1:0] r_out_cnt;
    logic [USED_W-1:0]   r_out_used;

    t_count              n_hit_cnt;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    t_count              mem_wcnt;

    assign n_hit_cnt = (r_rd_cnt == '1) ? r_rd_cnt : r_rd_cnt + t_count'(1);
    assign mem_we    = i_cmd.wr_hit || i_cmd.wr_new;
    assign mem_waddr = i_cmd.wr_new ? r_used[IDX_W-1:0] : r_rd_idx;
    assign mem_wcnt  = i_cmd.wr_new ? t_count'(1) : n_hit_cnt;

    always_comb begin
        o_sts             = '0;
        o_sts.op          = r_op;
        o_sts.pair        = r_pair;
        o_sts.in_range    = t_cmp'(r_ri) < t_cmp'(r_used);
        o_sts.more        = r_addr < r_used;
        o_sts.rd_vld      = r_rd_vld;
        o_sts.hit         = r_rd_key == {r_key_a, r_key_b};
        o_sts.full        = r_used == CNT_W'(TABLE_DEPTH);
        o_sts.out_blocked = r_out_valid && i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_key <= key_mem[r_addr[IDX_W-1:0]];
            r_rd_cnt <= cnt_mem[r_addr[IDX_W-1:0]];
        end
        if (i_cmd.wr_new) begin
            key_mem[mem_waddr] <= {r_key_a, r_key_b};
        end
        if (mem_we) begin
            cnt_mem[mem_waddr] <= mem_wcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_ri    <= i_read_index;
            r_key_a <= r_prev;
            r_key_b <= i_code_point;
            r_pair  <= (i_opcode == OP_CHAR) && r_prev_vld;
            if (i_opcode == OP_CHAR) begin
                r_prev <= i_code_point;
            end
        end
        if (i_cmd.rd) begin
            r_rd_idx <= r_addr[IDX_W-1:0];
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_status)
                ST_INCR: begin
                    r_res_idx <= INDEX_W'(r_rd_idx);
                    r_res_a   <= r_key_a;
                    r_res_b   <= r_key_b;
                    r_res_cnt <= PCOUNT_W'(n_hit_cnt);
                end
                ST_INSERT: begin
                    r_res_idx <= INDEX_W'(r_used);
                    r_res_a   <= r_key_a;
                    r_res_b   <= r_key_b;
                    r_res_cnt <= PCOUNT_W'(1);
                end
                ST_FULL: begin
                    r_res_idx <= '0;
                    r_res_a   <= r_key_a;
                    r_res_b   <= r_key_b;
                    r_res_cnt <= '0;
                end
                ST_READ_OK: begin
                    r_res_idx <= r_ri;
                    r_res_a   <= r_rd_key[KEY_W-1:CHAR_W];
                    r_res_b   <= r_rd_key[CHAR_W-1:0];
                    r_res_cnt <= PCOUNT_W'(r_rd_cnt);
                end
                ST_READ_OOR: begin
                    r_res_idx <= r_ri;
                    r_res_a   <= '0;
                    r_res_b   <= '0;
                    r_res_cnt <= '0;
                end
                default: begin
                    r_res_idx <= '0;
                    r_res_a   <= '0;
                    r_res_b   <= '0;
                    r_res_cnt <= '0;
                end
            endcase
        end
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
            r_out_a      <= r_res_a;
            r_out_b      <= r_res_b;
            r_out_cnt    <= r_res_cnt;
            r_out_used   <= USED_W'(r_used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_vld  <= 1'b0;
            r_used      <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.load) begin
                if (i_opcode == OP_CHAR) begin
                    r_prev_vld <= 1'b1;
                end else if (i_opcode == OP_EOL) begin
                    r_prev_vld <= 1'b0;
                end
                r_addr <= (i_opcode == OP_READ) ? CNT_W'(i_read_index) : '0;
            end else if (i_cmd.rd) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (i_cmd.wr_new) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_entry_index    = r_out_idx;
    assign o_first_char     = r_out_a;
    assign o_second_char    = r_out_b;
    assign o_pair_count     = r_out_cnt;
    assign o_entries_in_use = r_out_used;

endmodule
`default_nettype wire

### hw/rtl/char_bigram_frequency_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_bigram_frequency_table_top
// Counts adjacent character pairs within lines in a table searched in
// insertion order, and reads stored entries back by index.
// ----------------------------------------------------------------------------
// One request is processed at a time. A character that forms a pair scans the
// stored entries one per cycle through the single read port of the pair
// memories. The scan stops at a matching entry, and a miss scans every stored
// entry, so the worst case scans TABLE_DEPTH entries. A finished result waits
// in the output register while the next request is taken. The table needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module char_bigram_frequency_table_top
    import cbft_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic [CHAR_W-1:0]   i_code_point,
    input  wire logic [INDEX_W-1:0]  i_read_index,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [INDEX_W-1:0]       o_entry_index,
    output logic [CHAR_W-1:0]        o_first_char,
    output logic [CHAR_W-1:0]        o_second_char,
    output logic [PCOUNT_W-1:0]      o_pair_count,
    output logic [USED_W-1:0]        o_entries_in_use
);

    t_cmd cmd;
    t_sts sts;

    cbft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cbft_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_opcode         (i_opcode),
        .i_code_point     (i_code_point),
        .i_read_index     (i_read_index),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_entry_index    (o_entry_index),
        .o_first_char     (o_first_char),
        .o_second_char    (o_second_char),
        .o_pair_count     (o_pair_count),
        .o_entries_in_use (o_entries_in_use),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );

endmodule
`default_nettype wire

### tb/sv/char_bigram_frequency_table_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_bigram_frequency_table_top_test
// Drives character, end-of-line, read and unused requests into the bigram
// table at its default size and checks every result against a predictor
// kept in the bench.
// ----------------------------------------------------------------------------
module char_bigram_frequency_table_top_test;
    import cbft_pkg::*;

    localparam int TB_DEPTH = TABLE_DEPTH_DEF;
    localparam int TB_CNT_W = COUNT_WIDTH_DEF;
    localparam logic [TB_CNT_W-1:0] COUNT_MAX = {TB_CNT_W{1'b1}};
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [CHAR_W-1:0] CHAR_A = 21'h61;
    localparam logic [CHAR_W-1:0] CHAR_TOP = 21'h1FFFFF;
    localparam logic [CHAR_W-1:0] CHAR_UNICODE_MAX = 21'h10FFFF;
    localparam logic [INDEX_W-1:0] INDEX_TOP = 12'hFFF;
    localparam int HOLD_OFF_CYCLES = 150;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  entry_index;
        logic [CHAR_W-1:0]   first_char;
        logic [CHAR_W-1:0]   second_char;
        logic [PCOUNT_W-1:0] pair_count;
        logic [USED_W-1:0]   entries_in_use;
    } t_bigram_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [OPCODE_W-1:0] i_opcode = OP_EOL;
    logic [CHAR_W-1:0]   i_code_point = '0;
    logic [INDEX_W-1:0]  i_read_index = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [INDEX_W-1:0]  o_entry_index;
    logic [CHAR_W-1:0]   o_first_char;
    logic [CHAR_W-1:0]   o_second_char;
    logic [PCOUNT_W-1:0] o_pair_count;
    logic [USED_W-1:0]   o_entries_in_use;

    logic [CHAR_W-1:0]   prev_char = '0;
    logic                prev_valid = 1'b0;
    logic [CHAR_W-1:0]   key_first [TB_DEPTH];
    logic [CHAR_W-1:0]   key_second [TB_DEPTH];
    logic [TB_CNT_W-1:0] pair_count_mem [TB_DEPTH];
    int                  used_count = 0;

    t_bigram_result      pending_bigram_results [$];
    int                  mismatch_count = 0;
    bit                  tx_idle_on = 1'b1;
    bit                  rx_idle_on = 1'b1;
    int                  stall_left = 0;
    int                  hold_off_left = 0;

    char_bigram_frequency_table_top #(
        .TABLE_DEPTH(TB_DEPTH),
        .COUNT_WIDTH(TB_CNT_W)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_opcode(i_opcode),
        .i_code_point(i_code_point),
        .i_read_index(i_read_index),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_entry_index(o_entry_index),
        .o_first_char(o_first_char),
        .o_second_char(o_second_char),
        .o_pair_count(o_pair_count),
        .o_entries_in_use(o_entries_in_use)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_bigram_result predict_bigram(input logic [OPCODE_W-1:0] op,
                                                      input logic [CHAR_W-1:0] cp,
                                                      input logic [INDEX_W-1:0] ri);
        t_bigram_result r;
        int k;
        int hit;
        r = '0;
        r.status = ST_NO_PAIR;
        hit = -1;
        if (op == OP_CHAR) begin
            if (prev_valid) begin
                r.first_char = prev_char;
                r.second_char = cp;
                for (k = 0; k < used_count; k++) begin
                    if (hit < 0 && key_first[k] == prev_char && key_second[k] == cp) begin
                        hit = k;
                    end
                end
                if (hit >= 0) begin
                    if (pair_count_mem[hit] != COUNT_MAX) begin
                        pair_count_mem[hit]++;
                    end
                    r.status = ST_INCR;
                    r.entry_index = hit[INDEX_W-1:0];
                    r.pair_count = PCOUNT_W'(pair_count_mem[hit]);
                end else if (used_count < TB_DEPTH) begin
                    key_first[used_count] = prev_char;
                    key_second[used_count] = cp;
                    pair_count_mem[used_count] = TB_CNT_W'(1);
                    r.status = ST_INSERT;
                    r.entry_index = used_count[INDEX_W-1:0];
                    r.pair_count = PCOUNT_W'(1);
                    used_count++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            prev_char = cp;
            prev_valid = 1'b1;
        end else if (op == OP_EOL) begin
            prev_valid = 1'b0;
        end else if (op == OP_READ) begin
            r.entry_index = ri;
            if (ri < used_count) begin
                r.status = ST_READ_OK;
                r.first_char = key_first[ri];
                r.second_char = key_second[ri];
                r.pair_count = PCOUNT_W'(pair_count_mem[ri]);
            end else begin
                r.status = ST_READ_OOR;
            end
        end
        r.entries_in_use = used_count[USED_W-1:0];
        return r;
    endfunction

    // The task is entered and left just after a falling clock edge.
    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] cp,
                                input logic [INDEX_W-1:0] ri);
        int gap;
        gap = tx_idle_on ? int'($urandom_range(0, 7)) : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_opcode = op;
        i_code_point = cp;
        i_read_index = ri;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_bigram_results.push_back(predict_bigram(op, cp, ri));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] cp);
        send_request(OP_CHAR, cp, INDEX_W'($urandom_range(0, 4095)));
    endtask

    task automatic send_eol();
        send_request(OP_EOL, CHAR_W'($urandom_range(0, 2097151)),
                     INDEX_W'($urandom_range(0, 4095)));
    endtask

    task automatic send_read(input logic [INDEX_W-1:0] ri);
        send_request(OP_READ, CHAR_W'($urandom_range(0, 2097151)), ri);
    endtask

    function automatic void check_field(input string field, input logic [PCOUNT_W-1:0] want,
                                        input logic [PCOUNT_W-1:0] got);
        if (want !== got) begin
            if (mismatch_count < 40) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_bigram_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            stall_left = rx_idle_on ? int'($urandom_range(0, 7)) : 0;
            if (pending_bigram_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, o_status);
                mismatch_count++;
            end else begin
                want = pending_bigram_results.pop_front();
                check_field("status", PCOUNT_W'(want.status), PCOUNT_W'(o_status));
                check_field("entry_index", PCOUNT_W'(want.entry_index),
                            PCOUNT_W'(o_entry_index));
                check_field("first_char", PCOUNT_W'(want.first_char),
                            PCOUNT_W'(o_first_char));
                check_field("second_char", PCOUNT_W'(want.second_char),
                            PCOUNT_W'(o_second_char));
                check_field("pair_count", want.pair_count, o_pair_count);
                check_field("entries_in_use", PCOUNT_W'(want.entries_in_use),
                            PCOUNT_W'(o_entries_in_use));
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_stall = 1'b1;
            hold_off_left--;
        end else if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
        end
    end

    task automatic test_directed_cases();
        send_eol();
        send_read('0);
        send_char(CHAR_TOP);
        send_char('0);
        send_char('0);
        send_char('0);
        send_request(OP_UNUSED, CHAR_W'($urandom_range(0, 2097151)),
                     INDEX_W'($urandom_range(0, 4095)));
        send_char(CHAR_A);
        send_eol();
        send_eol();
        send_char(CHAR_A);
        send_char(CHAR_A);
        send_char(CHAR_UNICODE_MAX);
        send_read('0);
        send_read(INDEX_TOP);
        send_read(used_count[INDEX_W-1:0]);
        send_read(used_count[INDEX_W-1:0] - 1'b1);
        send_eol();
    endtask

    // Mostly well formed lines over a small alphabet, with reads and noise.
    task automatic test_random_text();
        int sent;
        int len;
        int n;
        sent = 0;
        while (sent < 100) begin
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
                7, 8: begin
                    if ($urandom_range(0, 1)) begin
                        send_read(INDEX_W'($urandom_range(0, used_count + 1)));
                    end else begin
                        send_read(INDEX_W'($urandom_range(0, 4095)));
                    end
                    sent++;
                end
                9: begin
                    send_request(OP_UNUSED, CHAR_W'($urandom_range(0, 2097151)),
                                 INDEX_W'($urandom_range(0, 4095)));
                    sent++;
                end
                default: begin
                    len = int'($urandom_range(0, 8));
                    for (n = 0; n < len; n++) begin
                        if ($urandom_range(0, 19) < 17) begin
                            send_char(CHAR_A + CHAR_W'($urandom_range(0, 3)));
                        end else begin
                            send_char(CHAR_W'($urandom_range(0, 2097151)));
                        end
                    end
                    sent += len;
                    if ($urandom_range(0, 7) != 0) begin
                        send_eol();
                        sent++;
                    end
                end
            endcase
        end
        send_eol();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        int n;
        tx_idle_on = 1'b0;
        @(posedge i_clk);
        hold_off_left = HOLD_OFF_CYCLES;
        @(negedge i_clk);
        for (n = 0; n < 20; n++) begin
            if (n % 4 == 3) begin
                send_read(INDEX_W'($urandom_range(0, used_count)));
            end else begin
                send_char(CHAR_A + CHAR_W'($urandom_range(0, 2)));
            end
        end
        send_eol();
        tx_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_cases();
        test_random_text();
        test_output_backpressure();
        i_valid = 1'b0;
        while (pending_bigram_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
